// File: src/assert_macros.svh
// assertion macros shared by the rtl files
// clocked on aclk, disabled while aresetn is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// combinational check sampled every clock
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: src/bhc_pkg.sv
// types and constants for the balance hysteresis controller
// no dependencies
package bhc_pkg;

    typedef enum logic [1:0] {
        MODE_REST   = 2'd0,
        MODE_MANUAL = 2'd1,
        MODE_AUTO   = 2'd2,
        MODE_STOP   = 2'd3
    } mode_t;

    localparam logic [1:0] DIR_NEG  = 2'd0;
    localparam logic [1:0] DIR_NONE = 2'd1;
    localparam logic [1:0] DIR_POS  = 2'd2;

    localparam logic [1:0] CMD_NONE      = 2'd0;
    localparam logic [1:0] CMD_START_POS = 2'd1;
    localparam logic [1:0] CMD_START_NEG = 2'd2;
    localparam logic [1:0] CMD_STOP      = 2'd3;

    localparam logic [3:0] LIM_NEG_END = 4'd7;
    localparam logic [3:0] LIM_POS_END = 4'd11;

    localparam logic [1:0] REG_MODE     = 2'd0;
    localparam logic [1:0] REG_MAN_DIR  = 2'd1;
    localparam logic [1:0] REG_ON_LEVEL = 2'd2;
    localparam logic [1:0] REG_OFF_LVL  = 2'd3;

    localparam int unsigned FRAC_BITS  = 16;
    localparam int unsigned FILT_W     = 32;
    localparam int unsigned DIFF_MAG_W = 33;

endpackage

// File: src/bhc_filter.sv
// exponential average update: f' = trunc((f * (n - 1) + sample * 2^16) / n)
// division by the constant n through an exact reciprocal multiply; uses bhc_pkg
module bhc_filter #(
    parameter int unsigned FILTER_LEN = 150
) (
    input  logic signed [bhc_pkg::FILT_W-1:0] filt_cur,
    input  logic signed [15:0]                sample,
    output logic signed [bhc_pkg::FILT_W-1:0] filt_next,
    output logic signed [15:0]                avg_int
);

    localparam int unsigned DIV_W   = bhc_pkg::DIFF_MAG_W;
    localparam int unsigned SHIFT   = DIV_W + $clog2(FILTER_LEN);
    localparam int unsigned RECIP_W = DIV_W + 1;
    localparam int unsigned PROD_W  = DIV_W + RECIP_W;
    localparam int unsigned Q_W     = PROD_W - SHIFT;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << SHIFT) + 64'(FILTER_LEN) - 64'd1) / 64'(FILTER_LEN));
    localparam logic [DIV_W-1:0] BIAS = DIV_W'(FILTER_LEN - 1);

    logic signed [bhc_pkg::FILT_W-1:0] scaled;
    logic signed [DIV_W-1:0]           diff;
    logic [DIV_W-1:0]                  diff_mag;
    logic [DIV_W-1:0]                  diff_mag_b;
    logic [PROD_W-1:0]                 prod_a;
    logic [PROD_W-1:0]                 prod_b;
    logic signed [RECIP_W-1:0]         quot_a;
    logic signed [RECIP_W-1:0]         quot_b;
    logic signed [RECIP_W-1:0]         floor_d;
    logic signed [RECIP_W-1:0]         ceil_d;
    logic signed [RECIP_W:0]           sum_fl;
    logic signed [RECIP_W:0]           sum_ce;

    assign scaled     = {sample, {bhc_pkg::FRAC_BITS{1'b0}}};
    assign diff       = {scaled[bhc_pkg::FILT_W-1], scaled} -
                        {filt_cur[bhc_pkg::FILT_W-1], filt_cur};
    assign diff_mag   = diff[DIV_W-1] ? (~diff + DIV_W'(1)) : diff;
    assign diff_mag_b = diff_mag + BIAS;

    // floor and ceiling of |d| / n side by side
    assign prod_a = PROD_W'(diff_mag) * PROD_W'(RECIP);
    assign prod_b = PROD_W'(diff_mag_b) * PROD_W'(RECIP);
    assign quot_a = $signed(RECIP_W'(prod_a[PROD_W-1:SHIFT]));
    assign quot_b = $signed(RECIP_W'(prod_b[PROD_W-1:SHIFT]));

    assign floor_d = diff[DIV_W-1] ? -quot_b : quot_a;
    assign ceil_d  = diff[DIV_W-1] ? -quot_a : quot_b;

    // f + floor(d/n) is non-negative exactly when the numerator is
    assign sum_fl = (RECIP_W+1)'(filt_cur) + (RECIP_W+1)'(floor_d);
    assign sum_ce = (RECIP_W+1)'(filt_cur) + (RECIP_W+1)'(ceil_d);

    assign filt_next = sum_fl[RECIP_W] ? sum_ce[bhc_pkg::FILT_W-1:0]
                                       : sum_fl[bhc_pkg::FILT_W-1:0];
    assign avg_int   = filt_next[bhc_pkg::FILT_W-1:bhc_pkg::FRAC_BITS];

endmodule

// File: src/balance_hysteresis_controller_unit.sv
// balance hysteresis controller top level: handshake stages, mode and hysteresis logic
// depends on bhc_pkg, bhc_filter and assert_macros.svh
//
// One transaction in, one result out, sustained at one per clock while m_ready is
// high. A sample is captured in the input register and its result is registered
// in the result register once that stage is free or being read; the filter update,
// mode decision and start/stop edge logic are all done in that one pass. The
// input stage keeps accepting while a result waits on m_ready until both stages
// are full. Configuration writes take effect at once and need no wait; writing
// balance_mode always releases a latched limit stop. No clearing pass after reset.
`include "assert_macros.svh"

module balance_hysteresis_controller_unit #(
    parameter int unsigned FILTER_LEN = 150
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [14:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_current_sample,
    input  logic               s_slewing,
    input  logic               s_elevation_scan,
    input  logic [3:0]         s_limit_switches,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_motor_command,
    output logic [1:0]         m_direction,
    output logic               m_move_enabled,
    output logic               m_motor_running,
    output logic signed [15:0] m_average_current,
    output logic               m_limit_stopped
);

    // configuration
    bhc_pkg::mode_t mode_reg;
    logic [1:0]     man_dir_reg;
    logic [14:0]    on_level_reg;
    logic [14:0]    off_level_reg;

    // controller state
    logic signed [bhc_pkg::FILT_W-1:0] filt_reg;
    logic [1:0]                        goal_reg;
    logic                              want_reg;
    logic                              running_reg;
    logic                              rest_latch_reg;
    logic                              rest_latch_next;

    // input stage
    logic               in_valid_reg;
    logic               in_valid_next;
    logic signed [15:0] in_sample_reg;
    logic               in_slew_reg;
    logic               in_scan_reg;
    logic [3:0]         in_lims_reg;

    // result stage
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [1:0]         out_cmd_reg;
    logic [1:0]         out_dir_reg;
    logic               out_want_reg;
    logic               out_run_reg;
    logic signed [15:0] out_avg_reg;
    logic               out_latch_reg;

    logic out_free;
    logic proc_fire;
    logic in_fire;
    logic mode_write;

    logic signed [bhc_pkg::FILT_W-1:0] filt_next;
    logic signed [15:0]                avg_int;

    logic signed [bhc_pkg::FILT_W:0] filt_ext;
    logic signed [bhc_pkg::FILT_W:0] on_pos;
    logic signed [bhc_pkg::FILT_W:0] on_neg;
    logic signed [bhc_pkg::FILT_W:0] off_pos;
    logic signed [bhc_pkg::FILT_W:0] off_neg;

    logic [1:0] step_goal;
    logic       step_want;
    logic       step_run;
    logic       step_latch;
    logic [1:0] step_cmd;

    bhc_filter #(
        .FILTER_LEN(FILTER_LEN)
    ) u_filter (
        .filt_cur (filt_reg),
        .sample   (in_sample_reg),
        .filt_next(filt_next),
        .avg_int  (avg_int)
    );

    // handshake
    assign out_free   = !out_valid_reg || m_ready;
    assign proc_fire  = in_valid_reg && out_free;
    assign s_ready    = !in_valid_reg || out_free;
    assign in_fire    = s_valid && s_ready;
    assign mode_write = cfg_wr_en && (cfg_index == bhc_pkg::REG_MODE);

    always_comb begin
        in_valid_next = in_valid_reg;
        if (in_fire) begin
            in_valid_next = 1'b1;
        end else if (proc_fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (proc_fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    // levels in q16.16
    assign filt_ext = {filt_next[bhc_pkg::FILT_W-1], filt_next};
    assign on_pos   = {2'b00, on_level_reg, {bhc_pkg::FRAC_BITS{1'b0}}};
    assign off_pos  = {2'b00, off_level_reg, {bhc_pkg::FRAC_BITS{1'b0}}};
    assign on_neg   = -on_pos;
    assign off_neg  = -off_pos;

    // mode decision, start/stop edges and limit check
    always_comb begin
        step_goal = goal_reg;
        step_want = want_reg;
        step_run  = running_reg;
        step_cmd  = bhc_pkg::CMD_NONE;

        if (rest_latch_reg || in_slew_reg || in_scan_reg) begin
            step_goal = bhc_pkg::DIR_NONE;
            step_want = 1'b0;
        end else begin
            case (mode_reg)
                bhc_pkg::MODE_MANUAL: begin
                    if (man_dir_reg inside {bhc_pkg::DIR_NEG, bhc_pkg::DIR_POS}) begin
                        step_goal = man_dir_reg;
                        step_want = 1'b1;
                    end else begin
                        step_goal = bhc_pkg::DIR_NONE;
                        step_want = 1'b0;
                    end
                end
                bhc_pkg::MODE_AUTO: begin
                    if (filt_ext > 0) begin
                        if (filt_ext > on_pos || (running_reg && filt_ext > off_pos)) begin
                            step_want = 1'b1;
                            step_goal = bhc_pkg::DIR_NEG;
                        end else if (running_reg) begin
                            step_goal = bhc_pkg::DIR_NONE;
                            step_want = 1'b0;
                        end
                    end else if (filt_ext < 0) begin
                        if (filt_ext < on_neg || (running_reg && filt_ext < off_neg)) begin
                            step_want = 1'b1;
                            step_goal = bhc_pkg::DIR_POS;
                        end else if (running_reg) begin
                            step_goal = bhc_pkg::DIR_NONE;
                            step_want = 1'b0;
                        end
                    end
                end
                default: begin
                    step_goal = bhc_pkg::DIR_NONE;
                    step_want = 1'b0;
                end
            endcase
        end

        if (step_want && !running_reg) begin
            if (step_goal == bhc_pkg::DIR_POS) begin
                step_cmd = bhc_pkg::CMD_START_POS;
            end else if (step_goal == bhc_pkg::DIR_NEG) begin
                step_cmd = bhc_pkg::CMD_START_NEG;
            end
            step_run = 1'b1;
        end else if (!step_want && running_reg) begin
            step_cmd = bhc_pkg::CMD_STOP;
            step_run = 1'b0;
        end

        step_latch = rest_latch_reg;
        if ((in_lims_reg == bhc_pkg::LIM_NEG_END && step_goal == bhc_pkg::DIR_NEG) ||
            (in_lims_reg == bhc_pkg::LIM_POS_END && step_goal == bhc_pkg::DIR_POS)) begin
            step_goal  = bhc_pkg::DIR_NONE;
            step_want  = 1'b0;
            step_run   = 1'b0;
            step_latch = 1'b1;
        end
    end

    always_comb begin
        rest_latch_next = rest_latch_reg;
        if (mode_write) begin
            rest_latch_next = 1'b0;
        end else if (proc_fire) begin
            rest_latch_next = step_latch;
        end
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= bhc_pkg::MODE_REST;
            man_dir_reg    <= bhc_pkg::DIR_NONE;
            on_level_reg   <= '0;
            off_level_reg  <= '0;
            filt_reg       <= '0;
            goal_reg       <= bhc_pkg::DIR_NONE;
            want_reg       <= 1'b0;
            running_reg    <= 1'b0;
            rest_latch_reg <= 1'b0;
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg   <= in_valid_next;
            out_valid_reg  <= out_valid_next;
            rest_latch_reg <= rest_latch_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    bhc_pkg::REG_MODE:     mode_reg      <= bhc_pkg::mode_t'(cfg_wdata[1:0]);
                    bhc_pkg::REG_MAN_DIR:  man_dir_reg   <= cfg_wdata[1:0];
                    bhc_pkg::REG_ON_LEVEL: on_level_reg  <= cfg_wdata;
                    bhc_pkg::REG_OFF_LVL:  off_level_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            if (proc_fire) begin
                filt_reg    <= filt_next;
                goal_reg    <= step_goal;
                want_reg    <= step_want;
                running_reg <= step_run;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            in_sample_reg <= s_current_sample;
            in_slew_reg   <= s_slewing;
            in_scan_reg   <= s_elevation_scan;
            in_lims_reg   <= s_limit_switches;
        end
        if (proc_fire) begin
            out_cmd_reg   <= step_cmd;
            out_dir_reg   <= step_goal;
            out_want_reg  <= step_want;
            out_run_reg   <= step_run;
            out_avg_reg   <= avg_int;
            out_latch_reg <= step_latch;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_motor_command   = out_cmd_reg;
    assign m_direction       = out_dir_reg;
    assign m_move_enabled    = out_want_reg;
    assign m_motor_running   = out_run_reg;
    assign m_average_current = out_avg_reg;
    assign m_limit_stopped   = out_latch_reg;

    // checks
    `ASSERT_IMPLY(a_run_follows_want, m_valid, m_move_enabled == m_motor_running,
        "running differs from wanted move")
    `ASSERT_IMPLY(a_latch_idle, m_valid && m_limit_stopped,
        !m_move_enabled && !m_motor_running && m_direction == bhc_pkg::DIR_NONE,
        "limit stop with a move pending")
    `ASSERT_IMPLY(a_start_runs, m_valid && (m_motor_command == bhc_pkg::CMD_START_POS ||
        m_motor_command == bhc_pkg::CMD_START_NEG), m_motor_running || m_limit_stopped,
        "start command without running motor")
    `ASSERT_ALWAYS(a_full_stall, !(in_valid_reg && out_valid_reg && !m_ready && s_ready),
        "ready high with both stages full")

endmodule

// File: verif/tb_balance_hysteresis_controller_unit.sv
// self-checking testbench for balance_hysteresis_controller_unit: a directed table, then random
// phases with register rewrites, each result checked against a tick-by-tick prediction
// depends on bhc_pkg and the rtl of balance_hysteresis_controller_unit
module tb_balance_hysteresis_controller_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FILTER_LEN = 150;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int RANDOM_TICKS = 600;
    localparam int QUIET_FROM = 520;
    localparam logic [1:0] DIR_UNUSED = 2'd3;

    typedef enum logic {ROW_WRITE, ROW_TICK} row_kind_t;

    typedef struct {
        row_kind_t kind;
        logic [1:0] idx;
        logic [14:0] val;
        logic signed [15:0] sample;
        logic slew;
        logic scan;
        logic [3:0] lims;
        bit typed;
        logic [1:0] cmd;
        logic [1:0] dir;
        logic en;
        logic run;
        logic latch;
    } row_t;

    typedef struct {
        logic [1:0] cmd;
        logic [1:0] dir;
        logic en;
        logic run;
        logic signed [15:0] avg;
        logic latch;
    } tick_out_t;

    logic aclk = 1'b0;
    logic aresetn;
    logic cfg_wr_en;
    logic [1:0] cfg_index;
    logic [14:0] cfg_wdata;
    logic s_valid;
    logic s_ready;
    logic signed [15:0] s_current_sample;
    logic s_slewing;
    logic s_elevation_scan;
    logic [3:0] s_limit_switches;
    logic m_valid;
    logic m_ready;
    logic [1:0] m_motor_command;
    logic [1:0] m_direction;
    logic m_move_enabled;
    logic m_motor_running;
    logic signed [15:0] m_average_current;
    logic m_limit_stopped;

    // mirrored registers and controller state
    bhc_pkg::mode_t cfg_mode = bhc_pkg::MODE_REST;
    logic [1:0] cfg_man_dir = bhc_pkg::DIR_NONE;
    logic [14:0] cfg_on_lvl = '0;
    logic [14:0] cfg_off_lvl = '0;
    int filt_q16 = 0;
    logic [1:0] goal_dir = bhc_pkg::DIR_NONE;
    logic want_run = 1'b0;
    logic motor_on = 1'b0;
    logic limit_latch = 1'b0;

    tick_out_t tick_results_due[$];
    row_t tick_hints[$];
    row_t plan[$];
    int mismatches = 0;
    int cycle_count = 0;
    int stall_pct = 0;
    bit quiet_tail = 1'b0;

    balance_hysteresis_controller_unit #(
        .FILTER_LEN(FILTER_LEN)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_current_sample(s_current_sample),
        .s_slewing(s_slewing),
        .s_elevation_scan(s_elevation_scan),
        .s_limit_switches(s_limit_switches),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_motor_command(m_motor_command),
        .m_direction(m_direction),
        .m_move_enabled(m_move_enabled),
        .m_motor_running(m_motor_running),
        .m_average_current(m_average_current),
        .m_limit_stopped(m_limit_stopped)
    );

    always #4 aclk = ~aclk;

    function automatic row_t write_row(logic [1:0] idx, logic [14:0] val);
        row_t r;
        r = '{kind: ROW_WRITE, idx: idx, val: val, default: '0};
        return r;
    endfunction

    function automatic row_t tick_row(logic signed [15:0] sample, logic slew, logic scan,
                                      logic [3:0] lims);
        row_t r;
        r = '{kind: ROW_TICK, sample: sample, slew: slew, scan: scan, lims: lims,
              default: '0};
        return r;
    endfunction

    function automatic row_t typed_row(logic signed [15:0] sample, logic slew, logic scan,
                                       logic [3:0] lims, logic [1:0] cmd, logic [1:0] dir,
                                       logic en, logic run, logic latch);
        row_t r;
        r = tick_row(sample, slew, scan, lims);
        r.typed = 1'b1;
        r.cmd = cmd;
        r.dir = dir;
        r.en = en;
        r.run = run;
        r.latch = latch;
        return r;
    endfunction

    function automatic void apply_write(logic [1:0] idx, logic [14:0] val);
        case (idx)
            bhc_pkg::REG_MODE: begin
                cfg_mode = bhc_pkg::mode_t'(val[1:0]);
                limit_latch = 1'b0;
            end
            bhc_pkg::REG_MAN_DIR: cfg_man_dir = val[1:0];
            bhc_pkg::REG_ON_LEVEL: cfg_on_lvl = val;
            default: cfg_off_lvl = val;
        endcase
    endfunction

    function automatic void drop_goal();
        want_run = 1'b0;
        goal_dir = bhc_pkg::DIR_NONE;
    endfunction

    function automatic tick_out_t control_tick(logic signed [15:0] sample, logic slew,
                                               logic scan, logic [3:0] lims);
        longint f;
        longint on_q16;
        longint off_q16;
        tick_out_t o;
        f = (longint'(filt_q16) * (FILTER_LEN - 1) + longint'(sample) * 65536) / FILTER_LEN;
        filt_q16 = int'(f);
        on_q16 = longint'(cfg_on_lvl) * 65536;
        off_q16 = longint'(cfg_off_lvl) * 65536;
        o.cmd = bhc_pkg::CMD_NONE;

        if (limit_latch || cfg_mode == bhc_pkg::MODE_REST || slew || scan) begin
            drop_goal();
        end else if (cfg_mode == bhc_pkg::MODE_MANUAL) begin
            if (cfg_man_dir == bhc_pkg::DIR_NEG || cfg_man_dir == bhc_pkg::DIR_POS) begin
                goal_dir = cfg_man_dir;
                want_run = 1'b1;
            end else begin
                drop_goal();
            end
        end else if (cfg_mode == bhc_pkg::MODE_AUTO) begin
            if (f > 0) begin
                if (f > on_q16 || (motor_on && f > off_q16)) begin
                    want_run = 1'b1;
                    goal_dir = bhc_pkg::DIR_NEG;
                end else if (motor_on) begin
                    drop_goal();
                end
            end else if (f < 0) begin
                if (f < -on_q16 || (motor_on && f < -off_q16)) begin
                    want_run = 1'b1;
                    goal_dir = bhc_pkg::DIR_POS;
                end else if (motor_on) begin
                    drop_goal();
                end
            end
        end else begin
            drop_goal();
        end

        if (want_run && !motor_on) begin
            if (goal_dir == bhc_pkg::DIR_POS) o.cmd = bhc_pkg::CMD_START_POS;
            else if (goal_dir == bhc_pkg::DIR_NEG) o.cmd = bhc_pkg::CMD_START_NEG;
            motor_on = 1'b1;
        end else if (!want_run && motor_on) begin
            o.cmd = bhc_pkg::CMD_STOP;
            motor_on = 1'b0;
        end

        if ((lims == bhc_pkg::LIM_NEG_END && goal_dir == bhc_pkg::DIR_NEG) ||
            (lims == bhc_pkg::LIM_POS_END && goal_dir == bhc_pkg::DIR_POS)) begin
            drop_goal();
            motor_on = 1'b0;
            limit_latch = 1'b1;
        end

        o.dir = goal_dir;
        o.en = want_run;
        o.run = motor_on;
        o.avg = 16'(f >>> 16);
        o.latch = limit_latch;
        return o;
    endfunction

    task automatic check_field(string name, logic signed [31:0] due, logic signed [31:0] got);
        if (got !== due) begin
            $error("%s: expected %0d, got %0d", name, due, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : scoreboard
        tick_out_t due;
        row_t hint;
        if (aresetn) begin
            if (cfg_wr_en) apply_write(cfg_index, cfg_wdata);
            if (s_valid && s_ready) begin
                due = control_tick(s_current_sample, s_slewing, s_elevation_scan,
                                   s_limit_switches);
                hint = tick_hints.pop_front();
                if (hint.typed) begin
                    due.cmd = hint.cmd;
                    due.dir = hint.dir;
                    due.en = hint.en;
                    due.run = hint.run;
                    due.latch = hint.latch;
                end
                tick_results_due.push_back(due);
            end
            if (m_valid && m_ready) begin
                if (tick_results_due.size() == 0) begin
                    $error("result transaction with nothing due");
                    mismatches++;
                end else begin
                    due = tick_results_due.pop_front();
                    check_field("motor_command", due.cmd, m_motor_command);
                    check_field("direction", due.dir, m_direction);
                    check_field("move_enabled", due.en, m_move_enabled);
                    check_field("motor_running", due.run, m_motor_running);
                    check_field("average_current", due.avg, m_average_current);
                    check_field("limit_stopped", due.latch, m_limit_stopped);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // result side back-pressure
    initial begin
        m_ready = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
            if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
            end
        end
    end

    task automatic offer_tick(row_t r);
        tick_hints.push_back(r);
        s_valid <= 1'b1;
        s_current_sample <= r.sample;
        s_slewing <= r.slew;
        s_elevation_scan <= r.scan;
        s_limit_switches <= r.lims;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tick_results_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [14:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [14:0] pick_level();
        case ($urandom_range(0, 4))
            0: return 15'd0;
            1: return 15'h7fff;
            2: return 15'($urandom_range(0, 400));
            default: return 15'($urandom_range(0, 32767));
        endcase
    endfunction

    function automatic row_t random_tick(int bias, int spread);
        int s;
        logic [3:0] lims;
        s = bias + int'($urandom_range(0, 2 * spread)) - spread;
        case ($urandom_range(0, 19))
            0: s = -32768;
            1: s = 32767;
            2: s = int'($urandom_range(0, 65535)) - 32768;
            default: ;
        endcase
        if (s > 32767) s = 32767;
        if (s < -32768) s = -32768;
        case ($urandom_range(0, 32))
            0: lims = bhc_pkg::LIM_NEG_END;
            1: lims = bhc_pkg::LIM_POS_END;
            default: lims = 4'($urandom_range(0, 15));
        endcase
        return tick_row(16'(s), $urandom_range(0, 19) == 0, $urandom_range(0, 19) == 0, lims);
    endfunction

    initial begin : stimulus
        int sent;
        int phase_len;
        int bias;
        int spread;
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = bhc_pkg::REG_MODE;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_current_sample = '0;
        s_slewing = 1'b0;
        s_elevation_scan = 1'b0;
        s_limit_switches = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        stall_pct = 30;
        plan = '{
            typed_row(0, 0, 0, 0, bhc_pkg::CMD_NONE, bhc_pkg::DIR_NONE, 0, 0, 0),
            typed_row(0, 1, 1, 15, bhc_pkg::CMD_NONE, bhc_pkg::DIR_NONE, 0, 0, 0),
            // zero average leaves auto mode untouched
            write_row(bhc_pkg::REG_MODE, bhc_pkg::MODE_AUTO),
            typed_row(0, 0, 0, 0, bhc_pkg::CMD_NONE, bhc_pkg::DIR_NONE, 0, 0, 0),
            write_row(bhc_pkg::REG_MODE, bhc_pkg::MODE_MANUAL),
            write_row(bhc_pkg::REG_MAN_DIR, bhc_pkg::DIR_POS),
            typed_row(0, 0, 0, 0, bhc_pkg::CMD_START_POS, bhc_pkg::DIR_POS, 1, 1, 0),
            write_row(bhc_pkg::REG_MODE, bhc_pkg::MODE_AUTO),
            typed_row(0, 0, 0, 0, bhc_pkg::CMD_NONE, bhc_pkg::DIR_POS, 1, 1, 0),
            write_row(bhc_pkg::REG_MODE, bhc_pkg::MODE_MANUAL),
            typed_row(0, 0, 0, 0, bhc_pkg::CMD_NONE, bhc_pkg::DIR_POS, 1, 1, 0),
            typed_row(0, 1, 0, 0, bhc_pkg::CMD_STOP, bhc_pkg::DIR_NONE, 0, 0, 0),
            typed_row(0, 0, 0, 0, bhc_pkg::CMD_START_POS, bhc_pkg::DIR_POS, 1, 1, 0),
            typed_row(0, 0, 0, bhc_pkg::LIM_POS_END, bhc_pkg::CMD_NONE, bhc_pkg::DIR_NONE,
                      0, 0, 1),
            typed_row(0, 0, 0, 0, bhc_pkg::CMD_NONE, bhc_pkg::DIR_NONE, 0, 0, 1),
            // same mode rewritten releases the latch, limit hit on the start tick
            write_row(bhc_pkg::REG_MODE, bhc_pkg::MODE_MANUAL),
            typed_row(0, 0, 0, bhc_pkg::LIM_POS_END, bhc_pkg::CMD_START_POS,
                      bhc_pkg::DIR_NONE, 0, 0, 1),
            write_row(bhc_pkg::REG_MODE, bhc_pkg::MODE_MANUAL),
            write_row(bhc_pkg::REG_MAN_DIR, bhc_pkg::DIR_NEG),
            typed_row(0, 0, 1, 0, bhc_pkg::CMD_NONE, bhc_pkg::DIR_NONE, 0, 0, 0),
            typed_row(0, 0, 0, bhc_pkg::LIM_POS_END, bhc_pkg::CMD_START_NEG,
                      bhc_pkg::DIR_NEG, 1, 1, 0),
            typed_row(0, 0, 0, bhc_pkg::LIM_NEG_END, bhc_pkg::CMD_NONE, bhc_pkg::DIR_NONE,
                      0, 0, 1),
            write_row(bhc_pkg::REG_MODE, bhc_pkg::MODE_MANUAL),
            write_row(bhc_pkg::REG_MAN_DIR, DIR_UNUSED),
            typed_row(0, 0, 0, 0, bhc_pkg::CMD_NONE, bhc_pkg::DIR_NONE, 0, 0, 0),
            write_row(bhc_pkg::REG_MAN_DIR, bhc_pkg::DIR_POS),
            typed_row(0, 0, 0, 0, bhc_pkg::CMD_START_POS, bhc_pkg::DIR_POS, 1, 1, 0),
            write_row(bhc_pkg::REG_MODE, bhc_pkg::MODE_STOP),
            typed_row(0, 0, 0, 0, bhc_pkg::CMD_STOP, bhc_pkg::DIR_NONE, 0, 0, 0),
            write_row(bhc_pkg::REG_MODE, bhc_pkg::MODE_AUTO),
            write_row(bhc_pkg::REG_ON_LEVEL, 15'd100),
            write_row(bhc_pkg::REG_OFF_LVL, 15'd50),
            tick_row(32767, 0, 0, 0),
            tick_row(32767, 0, 0, 0),
            tick_row(-32768, 0, 0, 0),
            tick_row(-32768, 0, 0, 0),
            tick_row(-32768, 0, 0, 0),
            write_row(bhc_pkg::REG_ON_LEVEL, 15'h7fff),
            write_row(bhc_pkg::REG_OFF_LVL, 15'h7fff),
            tick_row(-32768, 0, 0, 0),
            write_row(bhc_pkg::REG_ON_LEVEL, 15'd0),
            write_row(bhc_pkg::REG_OFF_LVL, 15'd0),
            tick_row(1, 0, 0, 0),
            tick_row(-1, 0, 0, 0)
        };
        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                settle();
                write_reg(plan[i].idx, plan[i].val);
            end else begin
                offer_tick(plan[i]);
            end
        end

        sent = 0;
        while (sent < RANDOM_TICKS) begin
            settle();
            if ($urandom_range(0, 9) < 7) begin
                case ($urandom_range(0, 7))
                    0: write_reg(bhc_pkg::REG_MODE, bhc_pkg::MODE_REST);
                    1: write_reg(bhc_pkg::REG_MODE, bhc_pkg::MODE_STOP);
                    2, 3: write_reg(bhc_pkg::REG_MODE, bhc_pkg::MODE_MANUAL);
                    default: write_reg(bhc_pkg::REG_MODE, bhc_pkg::MODE_AUTO);
                endcase
            end
            if ($urandom_range(0, 2) == 0) begin
                write_reg(bhc_pkg::REG_MAN_DIR, 15'($urandom_range(0, 3)));
            end
            if ($urandom_range(0, 1) == 0) write_reg(bhc_pkg::REG_ON_LEVEL, pick_level());
            if ($urandom_range(0, 1) == 0) write_reg(bhc_pkg::REG_OFF_LVL, pick_level());
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 10;
                2: stall_pct = 30;
                default: stall_pct = 60;
            endcase
            case ($urandom_range(0, 4))
                0: bias = 0;
                1: bias = int'($urandom_range(0, 800)) - 400;
                2: bias = $urandom_range(0, 1) ? 32000 : -32000;
                3: bias = int'($urandom_range(0, 65535)) - 32768;
                default: bias = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(2000, 10000));
            endcase
            case ($urandom_range(0, 3))
                0: spread = 0;
                1: spread = 50;
                2: spread = 2000;
                default: spread = 32767;
            endcase
            phase_len = $urandom_range(15, 60);
            for (int k = 0; k < phase_len && sent < RANDOM_TICKS; k++) begin
                quiet_tail = (sent >= QUIET_FROM);
                offer_tick(random_tick(bias, spread));
                sent++;
            end
        end

        settle();
        repeat (4) @(posedge aclk);
        if (tick_results_due.size() != 0) begin
            $error("%0d results never arrived", tick_results_due.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/bhc_pkg.sv
src/bhc_filter.sv
src/balance_hysteresis_controller_unit.sv
verif/tb_balance_hysteresis_controller_unit.sv
